@@ rtl/tspst_pkg.sv @@
// Shared constants, types and the stream classifier of the PID stream type table.
`default_nettype none
package tspst_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;
	localparam logic [1:0] OP_FIND   = 2'd3;

	localparam logic [2:0] CLS_UNKNOWN = 3'd0;
	localparam logic [2:0] CLS_KLVA    = 3'd1;
	localparam logic [2:0] CLS_EXI     = 3'd2;
	localparam logic [2:0] CLS_HDMV    = 3'd3;
	localparam logic [2:0] CLS_H264    = 3'd4;
	localparam logic [2:0] CLS_VIDEO   = 3'd5;
	localparam logic [2:0] CLS_AUDIO   = 3'd6;

	localparam logic [7:0] ST_PRIVATE  = 8'h06;
	localparam logic [7:0] ST_METADATA = 8'h15;
	localparam logic [7:0] ST_H264     = 8'h1B;
	localparam logic [7:0] ST_VIDEO    = 8'h02;
	localparam logic [7:0] ST_AUDIO1   = 8'h03;
	localparam logic [7:0] ST_AUDIO2   = 8'h04;

	localparam logic [31:0] FMT_KLVA      = 32'h4B4C5641;
	localparam logic [31:0] FMT_EXI       = 32'h24455849;
	localparam logic [31:0] FMT_HDMV_HEAD = 32'h48444D56;
	localparam logic [31:0] FMT_HDMV_TAIL = 32'hFF1B443F;
	localparam logic [31:0] FMT_HDPR_HEAD = 32'h48445052;
	localparam logic [31:0] FMT_HDPR_TAIL = 32'hFF1B673F;

	typedef struct packed {
		logic             load;
		logic             clear;
		logic             scan;
		logic [IDX_W-1:0] idx;
		logic             commit;
	} tspst_cmd_t;

	typedef struct packed {
		logic out_free;
	} tspst_stat_t;

	function automatic logic [2:0] classify(input logic [7:0] kind, input logic has_reg,
		input logic [31:0] head_in, input logic [31:0] tail_in, input logic [7:0] b8_in);
		logic [31:0] head;
		logic [31:0] tail;
		logic [7:0]  b8;
		logic [2:0]  cls;
		head = has_reg ? head_in : 32'd0;
		tail = has_reg ? tail_in : 32'd0;
		b8   = has_reg ? b8_in : 8'd0;
		cls  = CLS_UNKNOWN;
		if (kind == ST_PRIVATE || kind == ST_METADATA) begin
			if (head[31:24] == 8'd0 || head == FMT_KLVA)
				cls = CLS_KLVA;
			else if (head == FMT_EXI)
				cls = CLS_EXI;
		end else if (kind == ST_H264) begin
			if (b8 == 8'd0 && ((head == FMT_HDMV_HEAD && tail == FMT_HDMV_TAIL) ||
				(head == FMT_HDPR_HEAD && tail == FMT_HDPR_TAIL)))
				cls = CLS_HDMV;
			else
				cls = CLS_H264;
		end else if (kind == ST_VIDEO) begin
			cls = CLS_VIDEO;
		end else if (kind == ST_AUDIO1 || kind == ST_AUDIO2) begin
			cls = CLS_AUDIO;
		end
		return cls;
	endfunction

endpackage
`default_nettype wire

@@ rtl/tspst_ctrl.sv @@
// Controller state machine that sequences the table scan for each add, lookup and find item.
`default_nettype none
module tspst_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic [1:0]          opcode,
	input  wire tspst_pkg::tspst_stat_t stat,
	output logic                     in_ready,
	output tspst_pkg::tspst_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]                  state_q;
	logic [tspst_pkg::IDX_W-1:0] idx_q;
	logic                        load;
	logic                        commit;

	assign in_ready = (state_q == S_IDLE);
	assign load     = in_valid && in_ready;
	assign commit   = (state_q == S_DONE) && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (load)
						state_q <= (opcode == tspst_pkg::OP_CLEAR) ? S_DONE : S_SCAN;
				end
				S_SCAN: begin
					if (idx_q == tspst_pkg::IDX_LAST)
						state_q <= S_DONE;
					else
						idx_q <= idx_q + 1'b1;
				end
				S_DONE: begin
					if (commit)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.load   = load;
		cmd.clear  = load && (opcode == tspst_pkg::OP_CLEAR);
		cmd.scan   = (state_q == S_SCAN);
		cmd.idx    = idx_q;
		cmd.commit = commit;
	end

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> stat.out_free) else $error("result committed into a busy output");
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> state_q == S_IDLE) else $error("controller did not return to idle");
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		load && opcode == tspst_pkg::OP_CLEAR |=> state_q == S_DONE)
		else $error("clear item did not skip the scan");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> idx_q <= tspst_pkg::IDX_LAST)
		else $error("scan index out of range");

endmodule
`default_nettype wire

@@ rtl/tspst_dp.sv @@
// Datapath holding the PID table, the scan accumulators and the output register.
`default_nettype none
module tspst_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tspst_pkg::tspst_cmd_t cmd,
	output tspst_pkg::tspst_stat_t     stat,
	input  wire logic [1:0]            opcode,
	input  wire logic [12:0]           pid,
	input  wire logic [7:0]            stream_kind,
	input  wire logic                  has_registration,
	input  wire logic [31:0]           reg_head,
	input  wire logic [31:0]           reg_tail,
	input  wire logic [7:0]            reg_byte8,
	input  wire logic [2:0]            query_class,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       found,
	output logic [2:0]                 result_class,
	output logic [12:0]                result_pid,
	output logic                       table_full
);

	localparam int N = tspst_pkg::TABLE_ENTRIES;

	logic [N-1:0]                valid_q;
	logic [12:0]                 epid_q [N];
	logic [2:0]                  ecls_q [N];

	logic [1:0]                  op_q;
	logic [12:0]                 pid_q;
	logic [2:0]                  qc_q;
	logic [2:0]                  add_cls_q;
	logic                        hit_q;
	logic [2:0]                  hit_cls_q;
	logic [12:0]                 rpid_q;
	logic                        present_q;
	logic                        slot_ok_q;
	logic [tspst_pkg::IDX_W-1:0] slot_q;

	logic                        out_valid_q;
	logic                        found_q;
	logic [2:0]                  cls_q;
	logic [12:0]                 res_pid_q;
	logic                        full_q;

	logic                        cur_valid;
	logic [12:0]                 cur_pid;
	logic [2:0]                  cur_cls;
	logic                        insert;

	assign cur_valid = valid_q[cmd.idx];
	assign cur_pid   = epid_q[cmd.idx];
	assign cur_cls   = ecls_q[cmd.idx];
	assign insert    = (op_q == tspst_pkg::OP_ADD) && (add_cls_q != tspst_pkg::CLS_UNKNOWN)
		&& !present_q && slot_ok_q;

	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= opcode;
			pid_q     <= pid;
			qc_q      <= query_class;
			add_cls_q <= tspst_pkg::classify(stream_kind, has_registration, reg_head,
				reg_tail, reg_byte8);
			hit_q     <= 1'b0;
			hit_cls_q <= tspst_pkg::CLS_UNKNOWN;
			rpid_q    <= '0;
			present_q <= 1'b0;
			slot_ok_q <= 1'b0;
			slot_q    <= '0;
		end else if (cmd.scan) begin
			if (cur_valid) begin
				if (cur_pid == pid_q) begin
					present_q <= 1'b1;
					if (op_q == tspst_pkg::OP_LOOKUP && !hit_q) begin
						hit_q     <= 1'b1;
						hit_cls_q <= cur_cls;
					end
				end
				if (op_q == tspst_pkg::OP_FIND && cur_cls == qc_q) begin
					hit_q <= 1'b1;
					if (!hit_q || cur_pid < rpid_q)
						rpid_q <= cur_pid;
				end
			end else if (!slot_ok_q) begin
				slot_ok_q <= 1'b1;
				slot_q    <= cmd.idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && insert) begin
			epid_q[slot_q] <= pid_q;
			ecls_q[slot_q] <= add_cls_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear) begin
			valid_q <= '0;
		end else if (cmd.commit && insert) begin
			valid_q[slot_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			found_q   <= 1'b0;
			cls_q     <= tspst_pkg::CLS_UNKNOWN;
			res_pid_q <= '0;
			full_q    <= 1'b0;
			unique case (op_q)
				tspst_pkg::OP_CLEAR: begin
				end
				tspst_pkg::OP_ADD: begin
					cls_q   <= add_cls_q;
					found_q <= insert;
					full_q  <= (add_cls_q != tspst_pkg::CLS_UNKNOWN) && !present_q
						&& !slot_ok_q;
				end
				tspst_pkg::OP_LOOKUP: begin
					found_q <= hit_q;
					cls_q   <= hit_cls_q;
				end
				tspst_pkg::OP_FIND: begin
					found_q   <= hit_q;
					cls_q     <= qc_q;
					res_pid_q <= rpid_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign result_class = cls_q;
	assign result_pid   = res_pid_q;
	assign table_full   = full_q;

	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && insert |-> !valid_q[slot_q]) else $error("insert into an occupied entry");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q) else $error("pending result dropped");
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> valid_q == '0) else $error("clear left valid entries");

endmodule
`default_nettype wire

@@ rtl/ts_pid_stream_type_table_unit.sv @@
// Top level of the PID stream type table: controller and datapath.
// A clear item goes from idle straight to the done state; any other item first passes
// the sequential scan of the 16 table entries, one per cycle. The done state commits the
// result once the output is free; a new item is taken only in idle, after that commit.
// The output register lets the next item be taken while a result still waits.
// Reset is asynchronous and active low; it empties the table and drops any pending result.
`default_nettype none
module ts_pid_stream_type_table_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [12:0] pid,
	input  wire logic [7:0]  stream_kind,
	input  wire logic        has_registration,
	input  wire logic [31:0] reg_head,
	input  wire logic [31:0] reg_tail,
	input  wire logic [7:0]  reg_byte8,
	input  wire logic [2:0]  query_class,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             found,
	output logic [2:0]       result_class,
	output logic [12:0]      result_pid,
	output logic             table_full
);

	tspst_pkg::tspst_cmd_t  cmd;
	tspst_pkg::tspst_stat_t stat;

	tspst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	tspst_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.opcode           (opcode),
		.pid              (pid),
		.stream_kind      (stream_kind),
		.has_registration (has_registration),
		.reg_head         (reg_head),
		.reg_tail         (reg_tail),
		.reg_byte8        (reg_byte8),
		.query_class      (query_class),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.found            (found),
		.result_class     (result_class),
		.result_pid       (result_pid),
		.table_full       (table_full)
	);

endmodule
`default_nettype wire

@@ bench/ts_pid_table_checker.sv @@
// Checker for the PID stream type table: tracks the table contents and compares every result.
`timescale 1ns / 100ps
module ts_pid_table_checker
	import tspst_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [12:0] pid,
	input  wire logic [7:0]  stream_kind,
	input  wire logic        has_registration,
	input  wire logic [31:0] reg_head,
	input  wire logic [31:0] reg_tail,
	input  wire logic [7:0]  reg_byte8,
	input  wire logic [2:0]  query_class,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic        found,
	input  wire logic [2:0]  result_class,
	input  wire logic [12:0] result_pid,
	input  wire logic        table_full,
	output int               failures,
	output int               answers_due
);

	typedef struct packed {
		logic        found;
		logic [2:0]  cls;
		logic [12:0] pid;
		logic        full;
	} table_answer_t;

	logic          slot_used [TABLE_ENTRIES];
	logic [12:0]   slot_pid [TABLE_ENTRIES];
	logic [2:0]    slot_class [TABLE_ENTRIES];
	table_answer_t due_answers [$];
	int            reported;
	int            result_index;

	function automatic logic [2:0] stream_class_of(input logic [7:0] kind, input logic reg_on,
		input logic [31:0] head, input logic [31:0] tail, input logic [7:0] b8);
		logic [71:0] desc;
		desc = reg_on ? {head, tail, b8} : 72'd0;
		case (kind)
		ST_PRIVATE, ST_METADATA: begin
			if (desc[71:64] == 8'h00 || desc[71:40] == FMT_KLVA)
				return CLS_KLVA;
			if (desc[71:40] == FMT_EXI)
				return CLS_EXI;
			return CLS_UNKNOWN;
		end
		ST_H264: begin
			if (desc == {FMT_HDMV_HEAD, FMT_HDMV_TAIL, 8'h00} ||
				desc == {FMT_HDPR_HEAD, FMT_HDPR_TAIL, 8'h00})
				return CLS_HDMV;
			return CLS_H264;
		end
		ST_VIDEO: return CLS_VIDEO;
		ST_AUDIO1, ST_AUDIO2: return CLS_AUDIO;
		default: return CLS_UNKNOWN;
		endcase
	endfunction

	function automatic table_answer_t compute_table_answer(input logic [1:0] op,
		input logic [12:0] p, input logic [7:0] kind, input logic reg_on,
		input logic [31:0] head, input logic [31:0] tail, input logic [7:0] b8,
		input logic [2:0] qc);
		table_answer_t ans;
		int            free_slot;
		logic          present;
		int            i;
		ans = '0;
		free_slot = -1;
		present = 1'b0;
		case (op)
		OP_CLEAR: begin
			for (i = 0; i < TABLE_ENTRIES; i++)
				slot_used[i] = 1'b0;
		end
		OP_ADD: begin
			ans.cls = stream_class_of(kind, reg_on, head, tail, b8);
			if (ans.cls != CLS_UNKNOWN) begin
				for (i = 0; i < TABLE_ENTRIES; i++) begin
					if (slot_used[i] && slot_pid[i] == p)
						present = 1'b1;
					if (!slot_used[i] && free_slot < 0)
						free_slot = i;
				end
				if (!present) begin
					if (free_slot >= 0) begin
						slot_used[free_slot] = 1'b1;
						slot_pid[free_slot] = p;
						slot_class[free_slot] = ans.cls;
						ans.found = 1'b1;
					end else begin
						ans.full = 1'b1;
					end
				end
			end
		end
		OP_LOOKUP: begin
			for (i = 0; i < TABLE_ENTRIES; i++) begin
				if (slot_used[i] && slot_pid[i] == p && !ans.found) begin
					ans.found = 1'b1;
					ans.cls = slot_class[i];
				end
			end
		end
		OP_FIND: begin
			ans.cls = qc;
			for (i = 0; i < TABLE_ENTRIES; i++) begin
				if (slot_used[i] && slot_class[i] == qc &&
					(!ans.found || slot_pid[i] < ans.pid)) begin
					ans.pid = slot_pid[i];
					ans.found = 1'b1;
				end
			end
		end
		endcase
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_answer_t want;
		table_answer_t got;
		int            i;
		if (!arst_n) begin
			for (i = 0; i < TABLE_ENTRIES; i++)
				slot_used[i] = 1'b0;
			due_answers.delete();
			failures = 0;
			answers_due = 0;
			reported = 0;
			result_index = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {found, result_class, result_pid, table_full};
				if (due_answers.size() == 0) begin
					failures++;
					if (reported < 10)
						$display("Result %0d with no item pending: found=%0d class=%0d %s",
							result_index, got.found, got.cls,
							$sformatf("pid=%0d full=%0d", got.pid, got.full));
					reported++;
				end else begin
					want = due_answers.pop_front();
					if (got.found !== want.found || got.cls !== want.cls ||
						got.pid !== want.pid || got.full !== want.full) begin
						failures++;
						if (reported < 10) begin
							$display("Result %0d mismatch: expected found=%0d class=%0d %s",
								result_index, want.found, want.cls,
								$sformatf("pid=%0d full=%0d", want.pid, want.full));
							$display("Result %0d mismatch: actual found=%0d class=%0d %s",
								result_index, got.found, got.cls,
								$sformatf("pid=%0d full=%0d", got.pid, got.full));
						end
						reported++;
					end
				end
				result_index++;
			end
			if (in_valid && in_ready)
				due_answers.push_back(compute_table_answer(opcode, pid, stream_kind,
					has_registration, reg_head, reg_tail, reg_byte8, query_class));
			answers_due = due_answers.size();
		end
	end

endmodule

@@ bench/tb_ts_pid_stream_type_table_unit.sv @@
// Testbench top for the PID stream type table: stimulus, flow control and the verdict.
`timescale 1ns / 100ps
module tb_ts_pid_stream_type_table_unit;
	import tspst_pkg::*;

	localparam int RANDOM_ITEMS = 600;
	localparam int IDLE_LIMIT = 3000;

	typedef struct {
		logic [1:0]  op;
		logic [12:0] pid;
		logic [7:0]  kind;
		logic        has_reg;
		logic [31:0] head;
		logic [31:0] tail;
		logic [7:0]  b8;
		logic [2:0]  qc;
	} table_op_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode = OP_CLEAR;
	logic [12:0] pid = '0;
	logic [7:0]  stream_kind = '0;
	logic        has_registration = 1'b0;
	logic [31:0] reg_head = '0;
	logic [31:0] reg_tail = '0;
	logic [7:0]  reg_byte8 = '0;
	logic [2:0]  query_class = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        found;
	logic [2:0]  result_class;
	logic [12:0] result_pid;
	logic        table_full;
	int          failures;
	int          answers_due;
	int          idle_cycles = 0;
	int          stall_left = 0;
	logic        ready_level = 1'b1;

	always #1 clk = ~clk;

	ts_pid_stream_type_table_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.pid(pid),
		.stream_kind(stream_kind),
		.has_registration(has_registration),
		.reg_head(reg_head),
		.reg_tail(reg_tail),
		.reg_byte8(reg_byte8),
		.query_class(query_class),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.result_class(result_class),
		.result_pid(result_pid),
		.table_full(table_full)
	);

	ts_pid_table_checker table_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.pid(pid),
		.stream_kind(stream_kind),
		.has_registration(has_registration),
		.reg_head(reg_head),
		.reg_tail(reg_tail),
		.reg_byte8(reg_byte8),
		.query_class(query_class),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.result_class(result_class),
		.result_pid(result_pid),
		.table_full(table_full),
		.failures(failures),
		.answers_due(answers_due)
	);

	// The result side alternates between ready stretches and stalls of random length.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				ready_level = 1'b0;
				stall_left = $urandom_range(1, 40);
			end else begin
				ready_level = 1'b1;
				stall_left = $urandom_range(1, 60);
			end
		end else begin
			stall_left--;
		end
		out_ready <= ready_level;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic table_op_t op_item(input logic [1:0] op, input logic [12:0] p,
		input logic [7:0] kind, input logic has_reg, input logic [31:0] head,
		input logic [31:0] tail, input logic [7:0] b8, input logic [2:0] qc);
		table_op_t t;
		t.op = op;
		t.pid = p;
		t.kind = kind;
		t.has_reg = has_reg;
		t.head = head;
		t.tail = tail;
		t.b8 = b8;
		t.qc = qc;
		return t;
	endfunction

	// Adds (the commonest item) of known stream types and tags, lookups and finds over a small
	// PID pool, so that the table fills, holds duplicates and gets hit by lookups and finds.
	function automatic table_op_t random_table_op();
		table_op_t t;
		int        r;
		t.pid = 13'($urandom);
		t.kind = 8'($urandom);
		t.has_reg = 1'($urandom);
		t.head = $urandom;
		t.tail = $urandom;
		t.b8 = 8'($urandom);
		t.qc = 3'($urandom);
		r = $urandom_range(0, 99);
		if (r < 3)
			t.op = OP_CLEAR;
		else if (r < 52)
			t.op = OP_ADD;
		else if (r < 77)
			t.op = OP_LOOKUP;
		else
			t.op = OP_FIND;
		if ($urandom_range(0, 9) != 0) begin
			r = $urandom_range(0, 23);
			t.pid = (r == 0) ? 13'h0000 : (r == 1) ? 13'h1FFF : 13'(r * 331);
		end
		if (t.op == OP_ADD) begin
			case ($urandom_range(0, 9))
			0: t.kind = ST_PRIVATE;
			1: t.kind = ST_METADATA;
			2, 3: t.kind = ST_H264;
			4: t.kind = ST_VIDEO;
			5: t.kind = ST_AUDIO1;
			6: t.kind = ST_AUDIO2;
			default: ;
			endcase
			t.has_reg = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 7))
			0: t.head = FMT_KLVA;
			1: t.head = FMT_EXI;
			2: begin
				t.head = FMT_HDMV_HEAD;
				t.tail = FMT_HDMV_TAIL;
			end
			3: begin
				t.head = FMT_HDPR_HEAD;
				t.tail = FMT_HDPR_TAIL;
			end
			4: t.head[31:24] = 8'h00;
			5: begin
				t.head = FMT_HDMV_HEAD;
				t.tail = FMT_HDPR_TAIL;
			end
			default: ;
			endcase
			if ($urandom_range(0, 3) != 0)
				t.b8 = 8'h00;
			if ($urandom_range(0, 5) == 0) begin
				if ($urandom_range(0, 1) == 0)
					t.head ^= 32'h1 << $urandom_range(0, 31);
				else
					t.tail ^= 32'h1 << $urandom_range(0, 31);
			end
		end
		return t;
	endfunction

	task automatic send_item(input table_op_t t);
		opcode <= t.op;
		pid <= t.pid;
		stream_kind <= t.kind;
		has_registration <= t.has_reg;
		reg_head <= t.head;
		reg_tail <= t.tail;
		reg_byte8 <= t.b8;
		query_class <= t.qc;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (answers_due != 0);
	endtask

	initial begin
		int k;
		int sent;
		int burst;
		int gap;
		int r;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(op_item(OP_CLEAR, 13'h1FFF, 8'hFF, 1'b1, '1, '1, 8'hFF, 3'd7));
		send_item(op_item(OP_ADD, 13'h0000, ST_PRIVATE, 1'b0, '0, '0, 8'h00, CLS_UNKNOWN));
		send_item(op_item(OP_ADD, 13'h1FFF, ST_METADATA, 1'b1, FMT_KLVA, '0, 8'h00, CLS_KLVA));
		send_item(op_item(OP_ADD, 13'h0100, ST_PRIVATE, 1'b1, 32'h00FF_FFFF, '1, 8'hFF, CLS_KLVA));
		send_item(op_item(OP_ADD, 13'h0101, ST_METADATA, 1'b1, FMT_EXI, '0, 8'h00, CLS_EXI));
		send_item(op_item(OP_ADD, 13'h0102, ST_PRIVATE, 1'b1, 32'h4B4C_5642, '0, 8'h00, CLS_KLVA));
		send_item(op_item(OP_ADD, 13'h0103, ST_H264, 1'b1, FMT_HDMV_HEAD, FMT_HDMV_TAIL, 8'h00,
			CLS_HDMV));
		send_item(op_item(OP_ADD, 13'h0104, ST_H264, 1'b1, FMT_HDPR_HEAD, FMT_HDPR_TAIL, 8'h00,
			CLS_HDMV));
		send_item(op_item(OP_ADD, 13'h0105, ST_H264, 1'b1, FMT_HDMV_HEAD, FMT_HDMV_TAIL, 8'h01,
			CLS_H264));
		send_item(op_item(OP_ADD, 13'h0106, ST_H264, 1'b0, FMT_HDMV_HEAD, FMT_HDMV_TAIL, 8'h00,
			CLS_H264));
		send_item(op_item(OP_ADD, 13'h0107, ST_PRIVATE, 1'b0, FMT_EXI, '0, 8'h00, CLS_EXI));
		send_item(op_item(OP_ADD, 13'h0108, ST_VIDEO, 1'b0, '0, '0, 8'h00, CLS_VIDEO));
		send_item(op_item(OP_ADD, 13'h0109, ST_AUDIO1, 1'b1, '1, '1, 8'hFF, CLS_AUDIO));
		send_item(op_item(OP_ADD, 13'h010A, ST_AUDIO2, 1'b0, '0, '0, 8'h00, CLS_AUDIO));
		send_item(op_item(OP_ADD, 13'h010B, 8'hFF, 1'b1, FMT_KLVA, '0, 8'h00, CLS_UNKNOWN));
		send_item(op_item(OP_ADD, 13'h0000, ST_VIDEO, 1'b0, '0, '0, 8'h00, CLS_VIDEO));
		send_item(op_item(OP_LOOKUP, 13'h1FFF, 8'h00, 1'b0, '0, '0, 8'h00, CLS_UNKNOWN));
		send_item(op_item(OP_LOOKUP, 13'h1FFE, 8'h00, 1'b0, '0, '0, 8'h00, CLS_UNKNOWN));
		send_item(op_item(OP_FIND, 13'h0000, 8'h00, 1'b0, '0, '0, 8'h00, CLS_HDMV));
		send_item(op_item(OP_FIND, 13'h0000, 8'h00, 1'b0, '0, '0, 8'h00, CLS_UNKNOWN));
		send_item(op_item(OP_FIND, 13'h0000, 8'h00, 1'b0, '0, '0, 8'h00, 3'd7));
		// Fill the remaining slots, then one more add overflows the table.
		for (k = 0; k < 5; k++)
			send_item(op_item(OP_ADD, 13'h01F0 + 13'(k), ST_VIDEO, 1'b0, '0, '0, 8'h00,
				CLS_VIDEO));
		wait_drained();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 20);
			for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				send_item(random_table_op());
				sent++;
				if (sent == RANDOM_ITEMS / 2)
					wait_drained();
			end
			r = $urandom_range(0, 3);
			gap = (r == 0) ? 0 : (r == 1) ? $urandom_range(10, 30) : $urandom_range(1, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end

		wait_drained();
		repeat (40) @(negedge clk);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
